// ===== src/ihex_pkg.sv =====
// Shared types, constants and the hex digit decoder for the Intel HEX word stream block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package ihex_pkg;

    // Payload widths
    localparam int CHAR_W      = 8;
    localparam int ADDR_W      = 31;
    localparam int DATA_W      = 16;
    localparam int LINE_OUT_W  = 16;

    // Default of the internal line counter width
    localparam int LINE_NUMBER_BITS_DEF = 16;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'd58;

    // Record types that are acted on
    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EXT_LIN = 8'h04;

    // Result kinds
    localparam logic KIND_WORD  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // Saturation value of the reported line number
    localparam logic [LINE_OUT_W-1:0] LINE_OUT_MAX = 16'hFFFF;

    // One character beat held in the input register
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] code;
    } t_char_beat;

    // One result beat from the parser to the output register
    typedef struct packed {
        logic                  valid;
        logic                  kind;
        logic [ADDR_W-1:0]     word_address;
        logic [DATA_W-1:0]     word_data;
        logic [LINE_OUT_W-1:0] error_line;
    } t_result;

    // Decoded hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    // Decode one ASCII hex digit, either case
    function automatic t_hex hex_decode(input logic [CHAR_W-1:0] c);
        t_hex h;
        h.ok    = 1'b0;
        h.value = 4'd0;
        if (c >= 8'd48 && c <= 8'd57) begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'd48);
        end else if (c >= 8'd65 && c <= 8'd70) begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'd55);
        end else if (c >= 8'd97 && c <= 8'd102) begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'd87);
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== src/ihex_if.sv =====
// Valid/ready channel interfaces: character input and word/error result output.
// Depends on ihex_pkg for payload widths.
`default_nettype none

interface ihex_char_if;
    logic                         valid;
    logic                         ready;
    logic [ihex_pkg::CHAR_W-1:0]  char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface ihex_res_if;
    logic                             valid;
    logic                             ready;
    logic                             result_kind;
    logic [ihex_pkg::ADDR_W-1:0]      word_address;
    logic [ihex_pkg::DATA_W-1:0]      word_data;
    logic [ihex_pkg::LINE_OUT_W-1:0]  error_line;

    modport source (output valid, output result_kind, output word_address,
                    output word_data, output error_line, input ready);
    modport sink   (input valid, input result_kind, input word_address,
                    input word_data, input error_line, output ready);
endinterface

`default_nettype wire

// ===== src/ihex_in_reg.sv =====
// Input register: captures one character beat and holds it until the parser takes it.
// Depends on ihex_pkg and ihex_char_if.
`default_nettype none

module ihex_in_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    ihex_char_if.sink             i_char,
    input  wire                   i_advance,
    output ihex_pkg::t_char_beat  o_item
);

    logic                        r_valid;
    logic [ihex_pkg::CHAR_W-1:0] r_code;
    logic                        ready;

    // Free when empty or when the held beat is consumed this cycle
    assign ready        = !r_valid || i_advance;
    assign i_char.ready = ready;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_char.valid;
        end
    end

    // Load the character
    always_ff @(posedge i_clk) begin
        if (ready && i_char.valid) begin
            r_code <= i_char.char_code;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.code  = r_code;

endmodule

`default_nettype wire

// ===== src/ihex_parser.sv =====
// Record parser: field state, hex decode, word pairing and error detection.
// Depends on ihex_pkg; takes a beat from ihex_in_reg and feeds ihex_out_reg.
`default_nettype none

module ihex_parser #(
    parameter int LINE_NUMBER_BITS = ihex_pkg::LINE_NUMBER_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire ihex_pkg::t_char_beat  i_item,
    input  wire                        i_out_free,
    output logic                       o_advance,
    output ihex_pkg::t_result          o_res
);

    // Field phases
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_TAIL  = 3'd5;

    logic [2:0]                  r_phase,  n_phase;
    logic [1:0]                  r_nib,    n_nib;
    logic [7:0]                  r_count,  n_count;
    logic [7:0]                  r_didx,   n_didx;
    logic [15:0]                 r_addr,   n_addr;
    logic [7:0]                  r_type,   n_type;
    logic [7:0]                  r_pend,   n_pend;
    logic [15:0]                 r_upper,  n_upper;
    logic [LINE_NUMBER_BITS-1:0] r_line,   n_line;
    logic                        r_err,    n_err;
    logic [3:0]                  r_high,   n_high;

    ihex_pkg::t_hex              hexd;
    logic                        err;
    logic                        emit;
    logic [7:0]                  lo_byte;
    logic [7:0]                  hi_byte;
    logic [7:0]                  byte_v;
    logic [7:0]                  didx_inc;
    logic [31:0]                 byte_base;
    logic [ihex_pkg::ADDR_W-1:0] word_addr;
    logic [LINE_NUMBER_BITS-1:0] line_num;
    logic [31:0]                 line_wide;
    logic [ihex_pkg::LINE_OUT_W-1:0] err_line;

    assign o_advance = i_item.valid && i_out_free;

    // Decode the character and the datapath pieces
    assign hexd      = ihex_pkg::hex_decode(i_item.code);
    assign byte_v    = {r_high, hexd.value};
    assign didx_inc  = r_didx + 8'd1;
    assign byte_base = {r_upper, r_addr};
    assign word_addr = byte_base[31:1] + {{(ihex_pkg::ADDR_W-7){1'b0}}, r_didx[7:1]};

    // One-based line number, saturated to the counter and then to the port width
    assign line_num  = (r_line == '1) ? r_line : r_line + 1'b1;
    assign line_wide = 32'(line_num);
    assign err_line  = (line_wide > 32'(ihex_pkg::LINE_OUT_MAX)) ?
                       ihex_pkg::LINE_OUT_MAX : line_wide[ihex_pkg::LINE_OUT_W-1:0];

    // Advance the field state for one character
    always_comb begin
        n_phase = r_phase;
        n_nib   = r_nib;
        n_count = r_count;
        n_didx  = r_didx;
        n_addr  = r_addr;
        n_type  = r_type;
        n_pend  = r_pend;
        n_upper = r_upper;
        n_line  = r_line;
        n_err   = r_err;
        n_high  = r_high;
        err     = 1'b0;
        emit    = 1'b0;
        lo_byte = 8'd0;
        hi_byte = 8'd0;

        if (o_advance && !r_err) begin
            if (i_item.code == ihex_pkg::CH_LF) begin
                if (r_phase != PH_START && r_phase != PH_TAIL) begin
                    err = 1'b1;
                end else begin
                    n_phase = PH_START;
                    n_nib   = 2'd0;
                    if (r_line != '1) begin
                        n_line = r_line + 1'b1;
                    end
                end
            end else if (r_phase == PH_START) begin
                if (i_item.code != ihex_pkg::CH_COLON) begin
                    err = 1'b1;
                end else begin
                    n_phase = PH_COUNT;
                    n_nib   = 2'd0;
                    n_count = 8'd0;
                    n_addr  = 16'd0;
                    n_type  = 8'd0;
                    n_didx  = 8'd0;
                end
            end else if (r_phase != PH_TAIL) begin
                if (!hexd.ok) begin
                    err = 1'b1;
                end else begin
                    unique case (r_phase)
                        PH_COUNT: begin
                            n_count = {r_count[3:0], hexd.value};
                            if (r_nib == 2'd1) begin
                                n_nib   = 2'd0;
                                n_phase = PH_ADDR;
                            end else begin
                                n_nib = r_nib + 2'd1;
                            end
                        end
                        PH_ADDR: begin
                            n_addr = {r_addr[11:0], hexd.value};
                            if (r_nib == 2'd3) begin
                                n_nib   = 2'd0;
                                n_phase = PH_TYPE;
                            end else begin
                                n_nib = r_nib + 2'd1;
                            end
                        end
                        PH_TYPE: begin
                            n_type = {r_type[3:0], hexd.value};
                            if (r_nib == 2'd1) begin
                                n_nib   = 2'd0;
                                n_phase = (r_count != 8'd0) ? PH_DATA : PH_TAIL;
                            end else begin
                                n_nib = r_nib + 2'd1;
                            end
                        end
                        PH_DATA: begin
                            if (r_nib == 2'd0) begin
                                n_high = hexd.value;
                                n_nib  = 2'd1;
                            end else begin
                                n_nib = 2'd0;
                                if (r_type == ihex_pkg::REC_DATA) begin
                                    // Pair bytes little-endian; odd last byte pads high
                                    if (!r_didx[0]) begin
                                        n_pend = byte_v;
                                        if (didx_inc == r_count) begin
                                            emit    = 1'b1;
                                            lo_byte = byte_v;
                                        end
                                    end else begin
                                        emit    = 1'b1;
                                        lo_byte = r_pend;
                                        hi_byte = byte_v;
                                    end
                                end else if (r_type == ihex_pkg::REC_EXT_LIN) begin
                                    if (r_didx == 8'd0) begin
                                        n_pend = byte_v;
                                    end else if (r_didx == 8'd1) begin
                                        n_upper = {r_pend, byte_v};
                                    end
                                end
                                n_didx = didx_inc;
                                if (didx_inc == r_count) begin
                                    n_phase = PH_TAIL;
                                end
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
        end

        // Build the result beat
        o_res = '0;
        if (err) begin
            n_err            = 1'b1;
            o_res.valid      = 1'b1;
            o_res.kind       = ihex_pkg::KIND_ERROR;
            o_res.error_line = err_line;
        end else if (emit) begin
            o_res.valid        = 1'b1;
            o_res.kind         = ihex_pkg::KIND_WORD;
            o_res.word_address = word_addr;
            o_res.word_data    = {hi_byte, lo_byte};
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_nib   <= 2'd0;
            r_count <= 8'd0;
            r_didx  <= 8'd0;
            r_addr  <= 16'd0;
            r_type  <= 8'd0;
            r_pend  <= 8'd0;
            r_upper <= 16'd0;
            r_line  <= '0;
            r_err   <= 1'b0;
            r_high  <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_nib   <= n_nib;
            r_count <= n_count;
            r_didx  <= n_didx;
            r_addr  <= n_addr;
            r_type  <= n_type;
            r_pend  <= n_pend;
            r_upper <= n_upper;
            r_line  <= n_line;
            r_err   <= n_err;
            r_high  <= n_high;
        end
    end

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("error flag cleared without reset");

    a_quiet_after_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !o_res.valid)
        else $error("result produced after sticky error");

    a_res_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_advance)
        else $error("result produced without a consumed beat");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == ihex_pkg::KIND_ERROR) |->
        (o_res.word_address == '0 && o_res.word_data == '0 && o_res.error_line != '0))
        else $error("malformed error result");

    a_word_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == ihex_pkg::KIND_WORD) |->
        (r_phase == PH_DATA && r_nib == 2'd1 && r_type == ihex_pkg::REC_DATA
         && o_res.error_line == '0))
        else $error("word emitted outside a data byte");
`endif

endmodule

`default_nettype wire

// ===== src/ihex_out_reg.sv =====
// Result register: holds one result beat until the downstream side takes it.
// Depends on ihex_pkg and ihex_res_if.
`default_nettype none

module ihex_out_reg (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire ihex_pkg::t_result  i_res,
    output logic                    o_free,
    ihex_res_if.source              o_res
);

    logic                                r_valid;
    logic                                r_kind;
    logic [ihex_pkg::ADDR_W-1:0]         r_addr;
    logic [ihex_pkg::DATA_W-1:0]         r_data;
    logic [ihex_pkg::LINE_OUT_W-1:0]     r_line;

    // Free when empty or when the held beat leaves this cycle
    assign o_free = !r_valid || o_res.ready;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res.valid;
        end
    end

    // Load the payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_res.valid) begin
            r_kind <= i_res.kind;
            r_addr <= i_res.word_address;
            r_data <= i_res.word_data;
            r_line <= i_res.error_line;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.result_kind  = r_kind;
    assign o_res.word_address = r_addr;
    assign o_res.word_data    = r_data;
    assign o_res.error_line   = r_line;

endmodule

`default_nettype wire

// ===== src/intel_hex_to_word_stream.sv =====
// Intel HEX to word stream. Feed the text of a HEX file one character per beat; data
// records come out as 16-bit words (first byte low) at word address
// ((upper << 16) | record address) / 2 plus the pair index, where upper is set by
// extended linear address records. Other record types and the checksum are skipped.
// A line without a leading colon, a bad hex digit or a line cut short gives one error
// beat carrying the one-based line number; after that the block swallows all input
// until reset. The block takes one character every clock cycle unless the result side
// holds ready low, which is the only stall; each character waits in the input register
// and its result is loaded into the result register when the parser consumes it.
// Depends on ihex_pkg, ihex_if, ihex_in_reg, ihex_parser and ihex_out_reg.
`default_nettype none

module intel_hex_to_word_stream #(
    parameter int LINE_NUMBER_BITS = ihex_pkg::LINE_NUMBER_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ihex_char_if.sink   i_char,
    ihex_res_if.source  o_res
);

    ihex_pkg::t_char_beat item;
    ihex_pkg::t_result    res;
    logic                 advance;
    logic                 out_free;

    // Capture characters
    ihex_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (i_char),
        .i_advance (advance),
        .o_item    (item)
    );

    // Parse records
    ihex_parser #(
        .LINE_NUMBER_BITS (LINE_NUMBER_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_res      (res)
    );

    // Hold results
    ihex_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for intel_hex_to_word_stream: feeds HEX text one character per beat
// and checks every word and error beat against a cycle-free predictor of the parser.
// Depends on ihex_pkg, ihex_if and the block under test.
`default_nettype none

module testbench;

    localparam int    CYCLE_LIMIT  = 2_000_000;
    localparam int    RANDOM_CHARS = 380;
    localparam int    DRAIN_LIMIT  = 5000;
    localparam longint LINE_CAP    = (64'd1 << ihex_pkg::LINE_NUMBER_BITS_DEF) - 1;

    // Record types that the block skips
    localparam logic [7:0] REC_EOF       = 8'h01;
    localparam logic [7:0] REC_EXT_SEG   = 8'h02;
    localparam logic [7:0] REC_START_LIN = 8'h05;
    localparam logic [7:0] REC_UNKNOWN   = 8'hFF;

    // Parser position within a line
    typedef enum logic [2:0] {
        FLD_START, FLD_COUNT, FLD_ADDR, FLD_TYPE, FLD_DATA, FLD_TAIL
    } t_fld;

    typedef struct packed {
        logic                            kind;
        logic [ihex_pkg::ADDR_W-1:0]     addr;
        logic [ihex_pkg::DATA_W-1:0]     data;
        logic [ihex_pkg::LINE_OUT_W-1:0] line;
    } t_res_beat;

    typedef logic [7:0] t_char_q[$];

    logic i_clk;
    logic i_rst_n;

    ihex_char_if ch ();
    ihex_res_if  rs ();

    intel_hex_to_word_stream dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (ch),
        .o_res   (rs)
    );

    // Predicted parser state, starting at its reset values
    t_fld        ph            = FLD_START;
    int          nib_pos       = 0;
    logic [7:0]  rec_len       = '0;
    logic [7:0]  rec_idx       = '0;
    logic [15:0] rec_addr      = '0;
    logic [7:0]  rec_type      = '0;
    logic [7:0]  low_byte      = '0;
    logic [15:0] upper_addr    = '0;
    logic [3:0]  hi_nib        = '0;
    longint      lines_done    = 0;
    bit          error_latched = 1'b0;

    t_res_beat awaited_beats[$];

    int failures        = 0;
    int chars_accepted  = 0;
    int hold_request    = 0;
    bit tx_idle_on      = 1'b1;
    bit rx_idle_on      = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int digit_value(input logic [7:0] c);
        if (c >= 8'd48 && c <= 8'd57) return int'(c) - 48;
        if (c >= 8'd65 && c <= 8'd70) return int'(c) - 55;
        if (c >= 8'd97 && c <= 8'd102) return int'(c) - 87;
        return -1;
    endfunction

    function automatic void log_word(input logic [7:0] lo, input logic [7:0] hi);
        t_res_beat   beat;
        logic [31:0] byte_addr;
        byte_addr = {upper_addr, rec_addr};
        beat.kind = ihex_pkg::KIND_WORD;
        beat.addr = byte_addr[31:1] + ihex_pkg::ADDR_W'(rec_idx >> 1);
        beat.data = {hi, lo};
        beat.line = '0;
        awaited_beats = {awaited_beats, beat};
    endfunction

    function automatic void log_format_error();
        t_res_beat beat;
        longint    ln;
        ln = (lines_done >= LINE_CAP) ? LINE_CAP : lines_done + 1;
        if (ln > ihex_pkg::LINE_OUT_MAX) ln = ihex_pkg::LINE_OUT_MAX;
        beat.kind = ihex_pkg::KIND_ERROR;
        beat.addr = '0;
        beat.data = '0;
        beat.line = ln[ihex_pkg::LINE_OUT_W-1:0];
        error_latched = 1'b1;
        awaited_beats = {awaited_beats, beat};
    endfunction

    // Advance the predicted parser by one character
    function automatic void parse_char(input logic [7:0] c);
        int         v;
        logic [3:0] nv;
        logic [7:0] b;
        if (error_latched) return;
        if (c == ihex_pkg::CH_LF) begin
            if (ph != FLD_START && ph != FLD_TAIL) begin
                log_format_error();
                return;
            end
            ph      = FLD_START;
            nib_pos = 0;
            if (lines_done < LINE_CAP) lines_done++;
            return;
        end
        if (ph == FLD_START) begin
            if (c != ihex_pkg::CH_COLON) begin
                log_format_error();
                return;
            end
            ph       = FLD_COUNT;
            nib_pos  = 0;
            rec_len  = '0;
            rec_addr = '0;
            rec_type = '0;
            rec_idx  = '0;
            return;
        end
        if (ph == FLD_TAIL) return;
        v = digit_value(c);
        if (v < 0) begin
            log_format_error();
            return;
        end
        nv = v[3:0];
        case (ph)
            FLD_COUNT: begin
                rec_len = {rec_len[3:0], nv};
                if (nib_pos == 1) begin
                    nib_pos = 0;
                    ph      = FLD_ADDR;
                end else nib_pos++;
            end
            FLD_ADDR: begin
                rec_addr = {rec_addr[11:0], nv};
                if (nib_pos == 3) begin
                    nib_pos = 0;
                    ph      = FLD_TYPE;
                end else nib_pos++;
            end
            FLD_TYPE: begin
                rec_type = {rec_type[3:0], nv};
                if (nib_pos == 1) begin
                    nib_pos = 0;
                    ph      = (rec_len != 0) ? FLD_DATA : FLD_TAIL;
                end else nib_pos++;
            end
            default: begin
                if (nib_pos == 0) begin
                    hi_nib  = nv;
                    nib_pos = 1;
                end else begin
                    nib_pos = 0;
                    b       = {hi_nib, nv};
                    if (rec_type == ihex_pkg::REC_DATA) begin
                        if (!rec_idx[0]) begin
                            low_byte = b;
                            // odd count: last byte pads with a zero high byte
                            if (int'(rec_idx) + 1 == int'(rec_len)) log_word(b, 8'h00);
                        end else begin
                            log_word(low_byte, b);
                        end
                    end else if (rec_type == ihex_pkg::REC_EXT_LIN) begin
                        if (rec_idx == 0) low_byte = b;
                        else if (rec_idx == 1) upper_addr = {low_byte, b};
                    end
                    rec_idx++;
                    if (rec_idx == rec_len) ph = FLD_TAIL;
                end
            end
        endcase
    endfunction

    // Hex digit in random letter case
    function automatic logic [7:0] hex_glyph(input logic [3:0] n);
        if (n < 4'd10) return 8'd48 + 8'(n);
        if ($urandom_range(0, 1) == 0) return 8'd55 + 8'(n);
        return 8'd87 + 8'(n);
    endfunction

    function automatic void put_hex(ref t_char_q text, input logic [7:0] v);
        text = {text, hex_glyph(v[7:4])};
        text = {text, hex_glyph(v[3:0])};
    endfunction

    // Build one record line without its line feed; checksum and tail are random
    function automatic t_char_q line_text(input logic [7:0] rtype, input logic [15:0] raddr,
                                          input logic [7:0] payload[$], input int tail_len);
        t_char_q    text;
        logic [7:0] c;
        text = {text, ihex_pkg::CH_COLON};
        put_hex(text, 8'(payload.size()));
        put_hex(text, raddr[15:8]);
        put_hex(text, raddr[7:0]);
        put_hex(text, rtype);
        foreach (payload[i]) put_hex(text, payload[i]);
        put_hex(text, 8'($urandom_range(0, 255)));
        repeat (tail_len) begin
            c = 8'($urandom_range(0, 254));
            if (c >= ihex_pkg::CH_LF) c = c + 8'd1;
            text = {text, c};
        end
        return text;
    endfunction

    // Offer one character beat, with an optional idle burst first
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ch.valid     <= 1'b1;
        ch.char_code <= c;
        @(posedge i_clk);
        while (!ch.ready) @(posedge i_clk);
        parse_char(c);
        chars_accepted++;
    endtask

    task automatic send_line(input logic [7:0] rtype, input logic [15:0] raddr,
                             input logic [7:0] payload[$], input int tail_len);
        t_char_q text;
        text = line_text(rtype, raddr, payload, tail_len);
        foreach (text[i]) send_char(text[i]);
        send_char(ihex_pkg::CH_LF);
    endtask

    // Result side: long hold-off on request, else random stall bursts
    initial begin
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rs.ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                rs.ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                idle_left = $urandom_range(1, 5) - 1;
                rs.ready <= 1'b0;
            end else begin
                rs.ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string what, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
            failures++;
        end
    endfunction

    // Compare each result beat with the oldest prediction
    initial begin
        t_res_beat got;
        t_res_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rs.valid && rs.ready) begin
                got = {rs.result_kind, rs.word_address, rs.word_data, rs.error_line};
                if (awaited_beats.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got kind %0d addr 0x%0h data 0x%0h line %0d",
                             $time, got.kind, got.addr, got.data, got.line);
                    failures++;
                end else begin
                    want = awaited_beats.pop_front();
                    check_field("result_kind", want.kind, got.kind);
                    check_field("word_address", want.addr, got.addr);
                    check_field("word_data", want.data, got.data);
                    check_field("error_line", want.line, got.line);
                end
            end
        end
    end

    // Record kinds, odd and empty counts, address wrap and the largest count
    task automatic test_directed_lines();
        logic [7:0] bytes[$];
        send_char(ihex_pkg::CH_LF);
        bytes.delete();
        send_line(ihex_pkg::REC_DATA, 16'h0000, bytes, 0);
        bytes = '{8'h00, 8'hFF, 8'h5A};
        send_line(ihex_pkg::REC_DATA, 16'h0001, bytes, 2);
        bytes = '{8'hFF, 8'hFF};
        send_line(ihex_pkg::REC_EXT_LIN, 16'hFFFF, bytes, 0);
        bytes = '{8'h12, 8'h34, 8'h56, 8'h78};
        send_line(ihex_pkg::REC_DATA, 16'hFFFE, bytes, 0);
        // short extended address keeps the upper half
        bytes = '{8'hAB};
        send_line(ihex_pkg::REC_EXT_LIN, 16'h0000, bytes, 0);
        bytes = '{8'h11, 8'h22};
        send_line(ihex_pkg::REC_DATA, 16'h0000, bytes, 0);
        bytes = '{8'h00, 8'h00, 8'h77};
        send_line(ihex_pkg::REC_EXT_LIN, 16'h1234, bytes, 0);
        bytes = '{8'hFF, 8'hFF};
        send_line(ihex_pkg::REC_DATA, 16'h8000, bytes, 3);
        bytes = '{8'h01, 8'h02};
        send_line(REC_EOF, 16'h0000, bytes, 0);
        send_line(REC_EXT_SEG, 16'h0010, bytes, 0);
        send_line(REC_START_LIN, 16'hFFFF, bytes, 1);
        send_line(REC_UNKNOWN, 16'h5555, bytes, 0);
        send_char(ihex_pkg::CH_LF);
        bytes.delete();
        repeat (255) bytes = {bytes, 8'($urandom_range(0, 255))};
        send_line(ihex_pkg::REC_DATA, 16'($urandom_range(0, 65535)), bytes, 4);
    endtask

    // Hold the result side off while a long data record keeps arriving
    task automatic test_output_backpressure();
        logic [7:0] bytes[$];
        repeat (64) bytes = {bytes, 8'($urandom_range(0, 255))};
        hold_request = 300;
        send_line(ihex_pkg::REC_DATA, 16'($urandom_range(0, 65535)), bytes, 0);
    endtask

    // Mostly well-formed records with random content, some empty lines
    task automatic test_random_lines();
        logic [7:0] bytes[$];
        logic [7:0] rtype;
        int         start;
        int         pick;
        int         n;
        start = chars_accepted;
        while (chars_accepted - start < RANDOM_CHARS) begin
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_char(ihex_pkg::CH_LF);
            end else begin
                if (pick < 60) rtype = ihex_pkg::REC_DATA;
                else if (pick < 78) rtype = ihex_pkg::REC_EXT_LIN;
                else rtype = 8'($urandom_range(0, 255));
                if (rtype == ihex_pkg::REC_EXT_LIN && $urandom_range(0, 9) < 7) n = 2;
                else if ($urandom_range(0, 19) == 0) n = $urandom_range(17, 255);
                else n = $urandom_range(0, 16);
                bytes.delete();
                repeat (n) bytes = {bytes, 8'($urandom_range(0, 255))};
                send_line(rtype, 16'($urandom_range(0, 65535)),
                          bytes, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4));
            end
        end
    endtask

    // One format error, then ignored input
    task automatic test_sticky_error();
        t_char_q    text;
        logic [7:0] bytes[$];
        logic [7:0] c;
        int         cut;
        int         kind;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (4) bytes = {bytes, 8'($urandom_range(0, 255))};
        text = line_text(ihex_pkg::REC_DATA, 16'($urandom_range(0, 65535)), bytes, 0);
        // stop somewhere in the count, address, type or data fields
        cut  = $urandom_range(1, 16);
        kind = $urandom_range(0, 2);
        case (kind)
            0: begin
                // line without a leading colon
                do c = 8'($urandom_range(0, 255));
                while (c == ihex_pkg::CH_LF || c == ihex_pkg::CH_COLON);
                send_char(c);
            end
            1: begin
                // bad hex digit
                for (int i = 0; i < cut; i++) send_char(text[i]);
                do c = 8'($urandom_range(0, 255));
                while (c == ihex_pkg::CH_LF || digit_value(c) >= 0);
                send_char(c);
            end
            default: begin
                // line cut short
                for (int i = 0; i < cut; i++) send_char(text[i]);
                send_char(ihex_pkg::CH_LF);
            end
        endcase
        repeat (40) send_char(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int waited;
        ch.valid     = 1'b0;
        ch.char_code = '0;
        rs.ready     = 1'b0;
        i_rst_n      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_lines();
        test_output_backpressure();
        test_random_lines();
        test_sticky_error();
        ch.valid <= 1'b0;

        // Drain outstanding results, then allow the pipeline latency
        waited = 0;
        while (awaited_beats.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (awaited_beats.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, awaited_beats.size());
            failures += awaited_beats.size();
        end

        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
